FILE: design/truth_table_feature_classifier_core_macros.svh
// ---------------------------------------------------------------------------
// Truth table feature classifier assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TRUTH_TABLE_FEATURE_CLASSIFIER_CORE_MACROS_SVH
`define TRUTH_TABLE_FEATURE_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication.
`define TTFC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TTFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ttfc_pkg.sv
// ---------------------------------------------------------------------------
// Truth table feature classifier package
// Gate class codes, property bundle and constant masks over minterm positions.
// ---------------------------------------------------------------------------
package ttfc_pkg;

  localparam int unsigned CNT_W      = 3;
  localparam int unsigned TT_W       = 64;
  localparam int unsigned ONES_W     = 7;
  localparam int unsigned COST_W     = 6;
  localparam int unsigned INV_W      = 2;
  localparam int unsigned MAX_INPUTS = 6;
  localparam int unsigned NUM_WEIGHTS = MAX_INPUTS + 1;

  typedef enum logic [3:0] {
    CLS_CONST0 = 4'd0,
    CLS_CONST1 = 4'd1,
    CLS_BUF    = 4'd2,
    CLS_INV    = 4'd3,
    CLS_AND    = 4'd4,
    CLS_NAND   = 4'd5,
    CLS_OR     = 4'd6,
    CLS_NOR    = 4'd7,
    CLS_XOR    = 4'd8,
    CLS_XNOR   = 4'd9,
    CLS_MAJ    = 4'd10,
    CLS_MAJI   = 4'd11,
    CLS_AO     = 4'd12,
    CLS_AOI    = 4'd13,
    CLS_NONE   = 4'd14
  } gate_class_t;

  // Normalized table plus the structural properties of the function.
  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic [TT_W-1:0]   tt;
    logic [TT_W-1:0]   vmask;
    logic [ONES_W-1:0] ones;
    logic [2:0]        deg;
    logic              affine;
    logic              sym;
    logic              mono;
    logic              anti;
    logic [2:0]        nunate;
  } props_t;

  // Positions whose index has exactly w bits set.
  function automatic logic [TT_W-1:0] weight_mask(input int unsigned w);
    logic [TT_W-1:0] m;
    logic [5:0]      pv;
    m = '0;
    for (int p = 0; p < TT_W; p++) begin
      pv = 6'(p);
      if ($countones(pv) == w) m[p] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [TT_W-1:0] WEIGHT_MASK [NUM_WEIGHTS] = '{
    weight_mask(0), weight_mask(1), weight_mask(2), weight_mask(3),
    weight_mask(4), weight_mask(5), weight_mask(6)
  };

  localparam logic [TT_W-1:0] PARITY_MASK = weight_mask(1) | weight_mask(3) | weight_mask(5);
  localparam logic [TT_W-1:0] MAJ_MASK    = ~(weight_mask(0) | weight_mask(1));

  // Positions whose index bit i is zero.
  localparam logic [TT_W-1:0] LANE_MASK [MAX_INPUTS] = '{
    64'h5555_5555_5555_5555, 64'h3333_3333_3333_3333, 64'h0F0F_0F0F_0F0F_0F0F,
    64'h00FF_00FF_00FF_00FF, 64'h0000_FFFF_0000_FFFF, 64'h0000_0000_FFFF_FFFF
  };

  // Table bits in use for n inputs.
  function automatic logic [TT_W-1:0] valid_mask(input logic [CNT_W-1:0] n);
    logic [TT_W-1:0] m;
    case (n)
      3'd0:    m = 64'h0000_0000_0000_0001;
      3'd1:    m = 64'h0000_0000_0000_0003;
      3'd2:    m = 64'h0000_0000_0000_000F;
      3'd3:    m = 64'h0000_0000_0000_00FF;
      3'd4:    m = 64'h0000_0000_0000_FFFF;
      3'd5:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

FILE: design/ttfc_props.sv
// ---------------------------------------------------------------------------
// Truth table property extraction
// Masks the table, counts ones, runs the Moebius transform and checks
// symmetry, monotonicity and unateness per input.
// ---------------------------------------------------------------------------
module ttfc_props (
  input  logic [ttfc_pkg::CNT_W-1:0] in_count,
  input  logic [ttfc_pkg::TT_W-1:0]  tt_raw,
  output ttfc_pkg::props_t           props
);

  localparam logic [ttfc_pkg::CNT_W-1:0] NMAX = ttfc_pkg::CNT_W'(ttfc_pkg::MAX_INPUTS);

  logic [ttfc_pkg::CNT_W-1:0] n_sat;
  logic [ttfc_pkg::TT_W-1:0]  vm;
  logic [ttfc_pkg::TT_W-1:0]  t;
  logic [ttfc_pkg::TT_W-1:0]  anf [ttfc_pkg::MAX_INPUTS+1];
  logic [ttfc_pkg::TT_W-1:0]  lo;
  logic [ttfc_pkg::TT_W-1:0]  hi;
  logic [ttfc_pkg::TT_W-1:0]  wm;
  logic [ttfc_pkg::TT_W-1:0]  wv;
  logic [2:0]                 deg;
  logic [2:0]                 nunate;
  logic                       mono;
  logic                       anti;
  logic                       sym;

  always_comb begin
    n_sat = (in_count > NMAX) ? NMAX : in_count;
    vm    = ttfc_pkg::valid_mask(n_sat);
    t     = tt_raw & vm;

    // Moebius transform, one butterfly layer per active input
    anf[0] = t;
    for (int i = 0; i < ttfc_pkg::MAX_INPUTS; i++) begin
      if (3'(i) < n_sat) begin
        anf[i+1] = anf[i] ^ ((anf[i] & ttfc_pkg::LANE_MASK[i]) << (1 << i));
      end else begin
        anf[i+1] = anf[i];
      end
    end

    deg = 3'd0;
    for (int w = 1; w < ttfc_pkg::NUM_WEIGHTS; w++) begin
      if (|(anf[ttfc_pkg::MAX_INPUTS] & ttfc_pkg::WEIGHT_MASK[w])) deg = 3'(w);
    end

    mono   = 1'b1;
    anti   = 1'b1;
    nunate = 3'd0;
    for (int i = 0; i < ttfc_pkg::MAX_INPUTS; i++) begin
      lo = t & ttfc_pkg::LANE_MASK[i];
      hi = (t >> (1 << i)) & ttfc_pkg::LANE_MASK[i];
      if (3'(i) < n_sat) begin
        if (|(lo & ~hi)) mono = 1'b0;
        if (|(hi & ~lo)) begin
          anti = 1'b0;
        end else begin
          nunate = nunate + 3'd1;
        end
      end
    end

    // every weight class must be uniformly zero or uniformly one
    sym = 1'b1;
    for (int w = 0; w < ttfc_pkg::NUM_WEIGHTS; w++) begin
      wm = ttfc_pkg::WEIGHT_MASK[w] & vm;
      wv = t & wm;
      if ((wv != '0) && (wv != wm)) sym = 1'b0;
    end

    props.n      = n_sat;
    props.tt     = t;
    props.vmask  = vm;
    props.ones   = ttfc_pkg::ONES_W'($countones(t));
    props.deg    = deg;
    props.affine = (deg <= 3'd1);
    props.sym    = sym;
    props.mono   = mono;
    props.anti   = anti;
    props.nunate = nunate;
  end

endmodule

FILE: design/ttfc_classify.sv
// ---------------------------------------------------------------------------
// Truth table gate classifier
// Matches the masked table against the known gate shapes and derives the
// transistor cost and output inverter count of the class.
// ---------------------------------------------------------------------------
module ttfc_classify (
  input  ttfc_pkg::props_t              props,
  output ttfc_pkg::gate_class_t         gate_class,
  output logic [ttfc_pkg::COST_W-1:0]   cost,
  output logic [ttfc_pkg::INV_W-1:0]    inverters
);

  localparam logic [ttfc_pkg::COST_W-1:0] XOR_BASE_COST = 6'd10;
  localparam logic [ttfc_pkg::COST_W-1:0] MAJ_COST      = 6'd12;
  localparam logic [ttfc_pkg::COST_W-1:0] MAJI_COST     = 6'd10;
  localparam logic [ttfc_pkg::COST_W-1:0] BUF_COST      = 6'd4;
  localparam logic [ttfc_pkg::COST_W-1:0] INV_COST      = 6'd2;

  logic [ttfc_pkg::TT_W-1:0]   t;
  logic [ttfc_pkg::TT_W-1:0]   vm;
  logic [ttfc_pkg::TT_W-1:0]   top;
  logic                        f_lo;
  logic                        f_hi;
  logic [ttfc_pkg::COST_W-1:0] two_n;
  ttfc_pkg::gate_class_t       cls;

  always_comb begin
    t     = props.tt;
    vm    = props.vmask;
    top   = vm & ~(vm >> 1);   // the all-ones minterm
    f_lo  = t[0];
    f_hi  = |(t & top);
    two_n = ttfc_pkg::COST_W'({props.n, 1'b0});

    if (t == '0) begin
      cls = ttfc_pkg::CLS_CONST0;
    end else if (t == vm) begin
      cls = ttfc_pkg::CLS_CONST1;
    end else if (props.n == 3'd1) begin
      if (t == 64'd2)      cls = ttfc_pkg::CLS_BUF;
      else if (t == 64'd1) cls = ttfc_pkg::CLS_INV;
      else                 cls = ttfc_pkg::CLS_NONE;
    end else if (t == top) begin
      cls = ttfc_pkg::CLS_AND;
    end else if (t == (vm & ~top)) begin
      cls = ttfc_pkg::CLS_NAND;
    end else if (t == (vm & ~64'd1)) begin
      cls = ttfc_pkg::CLS_OR;
    end else if (t == 64'd1) begin
      cls = ttfc_pkg::CLS_NOR;
    end else if (t == (vm & ttfc_pkg::PARITY_MASK)) begin
      cls = ttfc_pkg::CLS_XOR;
    end else if (t == (vm & ~ttfc_pkg::PARITY_MASK)) begin
      cls = ttfc_pkg::CLS_XNOR;
    end else if ((props.n == 3'd3) && (t == (vm & ttfc_pkg::MAJ_MASK))) begin
      cls = ttfc_pkg::CLS_MAJ;
    end else if ((props.n == 3'd3) && (t == (vm & ~ttfc_pkg::MAJ_MASK))) begin
      cls = ttfc_pkg::CLS_MAJI;
    end else if (props.mono) begin
      cls = (!f_lo && f_hi) ? ttfc_pkg::CLS_AO : ttfc_pkg::CLS_NONE;
    end else if (props.anti) begin
      cls = (f_lo && !f_hi) ? ttfc_pkg::CLS_AOI : ttfc_pkg::CLS_NONE;
    end else begin
      cls = ttfc_pkg::CLS_NONE;
    end

    unique case (cls)
      ttfc_pkg::CLS_BUF:  cost = BUF_COST;
      ttfc_pkg::CLS_INV:  cost = INV_COST;
      ttfc_pkg::CLS_NAND,
      ttfc_pkg::CLS_NOR,
      ttfc_pkg::CLS_AOI:  cost = two_n;
      ttfc_pkg::CLS_AND,
      ttfc_pkg::CLS_OR,
      ttfc_pkg::CLS_AO:   cost = two_n + 6'd2;
      ttfc_pkg::CLS_XOR,
      ttfc_pkg::CLS_XNOR: begin
        // 10 for two inputs, 8 more per extra input
        if (props.n >= 3'd2) begin
          cost = XOR_BASE_COST + ttfc_pkg::COST_W'({3'(props.n - 3'd2), 3'b000});
        end else begin
          cost = '0;
        end
      end
      ttfc_pkg::CLS_MAJ:  cost = MAJ_COST;
      ttfc_pkg::CLS_MAJI: cost = MAJI_COST;
      default:            cost = '0;
    endcase

    unique case (cls)
      ttfc_pkg::CLS_BUF: inverters = 2'd2;
      ttfc_pkg::CLS_AND,
      ttfc_pkg::CLS_OR,
      ttfc_pkg::CLS_AO,
      ttfc_pkg::CLS_MAJ: inverters = 2'd1;
      default:           inverters = 2'd0;
    endcase

    gate_class = cls;
  end

endmodule

FILE: design/truth_table_feature_classifier_core.sv
// ---------------------------------------------------------------------------
// Truth table feature classifier core
// Classifies a Boolean function of up to six inputs from its truth table.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one item is an input count and a
//   64-bit truth table, bit p holding the output for minterm p. Counts above
//   six saturate; table bits from index 2^n up are ignored.
//   Result channel (out_valid / out_stall): one item per input item with the
//   gate class, weight, ANF degree, affine/symmetric/monotone/antimonotone flags, the
//   negative-unate input count, transistor cost and output inverter count.
//   Path: the accepting edge loads the input register, and the item then
//   moves into the result register once that is free, which raises
//   out_valid. Throughput: one item per cycle while out_stall is low, set
//   by the single combinational pass between those two registers.
//   Stall: while out_stall holds a result, one more item is taken into the
//   input register; in_stall rises only when both registers are full.
//   Reset: rst_n low (synchronous) empties both stages; no item survives.
//   Results come out in input order.
// ---------------------------------------------------------------------------
`include "truth_table_feature_classifier_core_macros.svh"

module truth_table_feature_classifier_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ttfc_pkg::CNT_W-1:0]    in_input_count,
  input  logic [ttfc_pkg::TT_W-1:0]     in_truth_table,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    out_gate_class,
  output logic [ttfc_pkg::ONES_W-1:0]   out_ones_count,
  output logic [2:0]                    out_alg_degree,
  output logic                          out_affine_flag,
  output logic                          out_symmetric_flag,
  output logic                          out_monotone_flag,
  output logic                          out_antimonotone_flag,
  output logic [2:0]                    out_neg_unate_inputs,
  output logic [ttfc_pkg::COST_W-1:0]   out_transistor_cost,
  output logic [ttfc_pkg::INV_W-1:0]    out_output_inverters
);

  // input stage
  logic                          s1_valid_r, s1_valid_nxt;
  logic [ttfc_pkg::CNT_W-1:0]    s1_count_r;
  logic [ttfc_pkg::TT_W-1:0]     s1_tt_r;

  // result stage
  logic                          out_valid_r, out_valid_nxt;
  ttfc_pkg::gate_class_t         cls_r;
  logic [ttfc_pkg::ONES_W-1:0]   ones_r;
  logic [2:0]                    deg_r;
  logic                          affine_r;
  logic                          sym_r;
  logic                          mono_r;
  logic                          anti_r;
  logic [2:0]                    nunate_r;
  logic [ttfc_pkg::COST_W-1:0]   cost_r;
  logic [ttfc_pkg::INV_W-1:0]    inv_r;

  logic                          in_accept;
  logic                          out_adv;
  logic                          s1_move;

  ttfc_pkg::props_t              props;
  ttfc_pkg::gate_class_t         cls;
  logic [ttfc_pkg::COST_W-1:0]   cost;
  logic [ttfc_pkg::INV_W-1:0]    inv;

  // Result register can load when empty or when its item leaves this cycle.
  assign out_adv   = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_adv;
  assign in_stall  = s1_valid_r && !out_adv;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    // advance the input stage on accept, drop it once it moves on
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (out_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: hold unless a new item lands.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_count_r <= in_input_count;
      s1_tt_r    <= in_truth_table;
    end
    if (s1_move) begin
      cls_r    <= cls;
      ones_r   <= props.ones;
      deg_r    <= props.deg;
      affine_r <= props.affine;
      sym_r    <= props.sym;
      mono_r   <= props.mono;
      anti_r   <= props.anti;
      nunate_r <= props.nunate;
      cost_r   <= cost;
      inv_r    <= inv;
    end
  end

  // Single combinational pass: properties, then class match.
  ttfc_props u_props (
    .in_count (s1_count_r),
    .tt_raw   (s1_tt_r),
    .props    (props)
  );

  ttfc_classify u_classify (
    .props      (props),
    .gate_class (cls),
    .cost       (cost),
    .inverters  (inv)
  );

  assign out_valid             = out_valid_r;
  assign out_gate_class        = cls_r;
  assign out_ones_count        = ones_r;
  assign out_alg_degree        = deg_r;
  assign out_affine_flag       = affine_r;
  assign out_symmetric_flag    = sym_r;
  assign out_monotone_flag     = mono_r;
  assign out_antimonotone_flag = anti_r;
  assign out_neg_unate_inputs  = nunate_r;
  assign out_transistor_cost   = cost_r;
  assign out_output_inverters  = inv_r;

  // Backpressure only when both stages hold an item and the receiver stalls.
  `TTFC_ASSERT_IMPLY(a_stall_cause, in_stall,
    s1_valid_r && out_valid_r && out_stall, "in_stall without full pipeline")
  // A waiting input item reaches the result register when it is free.
  `TTFC_ASSERT_NEXT(a_advance, s1_valid_r && out_adv, out_valid_r,
    "input item did not advance")
  // Unclassified functions carry no cost.
  `TTFC_ASSERT_IMPLY(a_none_zero, out_valid && (out_gate_class == ttfc_pkg::CLS_NONE),
    (out_transistor_cost == 6'd0) && (out_output_inverters == 2'd0),
    "unclassified item has cost")
  // Affine flag follows the degree.
  `TTFC_ASSERT_IMPLY(a_affine, out_valid, out_affine_flag == (out_alg_degree <= 3'd1),
    "affine flag mismatch")
  // Constant zero has no ones and degree zero.
  `TTFC_ASSERT_IMPLY(a_const0, out_valid && (out_gate_class == ttfc_pkg::CLS_CONST0),
    (out_ones_count == 7'd0) && (out_alg_degree == 3'd0), "const0 item inconsistent")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Truth table feature classifier core testbench
// Feeds truth tables, some hand-picked and many drawn at random with
// structure, through the core. A local classifier works out each result and
// every result is matched field by field. Both sides idle in random bursts.
// ---------------------------------------------------------------------------
module tb;

  localparam int RANDOM_ITEMS = 1825;
  localparam int CALM_FROM    = RANDOM_ITEMS - 200;
  localparam int LONG_HOLD    = 60;
  localparam int RUSH_ITEMS   = 30;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT_NS   = 5_000_000;

  // Minterm positions whose index bit i is clear.
  localparam bit [63:0] LANE_ZERO [6] = '{
    64'h5555_5555_5555_5555, 64'h3333_3333_3333_3333, 64'h0F0F_0F0F_0F0F_0F0F,
    64'h00FF_00FF_00FF_00FF, 64'h0000_FFFF_0000_FFFF, 64'h0000_0000_FFFF_FFFF
  };

  typedef struct packed {
    ttfc_pkg::gate_class_t cls;
    logic [6:0]  ones;
    logic [2:0]  deg;
    logic        affine;
    logic        sym;
    logic        mono;
    logic        anti;
    logic [2:0]  nunate;
    logic [5:0]  cost;
    logic [1:0]  inv;
  } verdict_t;

  // Holds the features owed by the core, oldest first, and judges results.
  class feature_ledger;
    verdict_t    pending[$];
    int unsigned faults;

    static function bit [63:0] span_of(int n);
      return (n >= 6) ? '1 : ((64'd1 << (1 << n)) - 64'd1);
    endfunction

    // Work out every feature of the function the core should report.
    function verdict_t classify(bit [2:0] cnt, bit [63:0] tbl);
      verdict_t  v;
      int        n, sz, full, pw, top;
      bit [63:0] vm, t, anf, par, mj, lo, hi;
      bit        seen [7];
      bit        val [7];
      v = '0;
      v.sym = 1'b1;
      v.mono = 1'b1;
      v.anti = 1'b1;
      top = 0;
      par = '0;
      mj = '0;
      n = (cnt > ttfc_pkg::MAX_INPUTS) ? ttfc_pkg::MAX_INPUTS : cnt;
      sz = 1 << n;
      full = sz - 1;
      vm = span_of(n);
      t = tbl & vm;
      foreach (seen[w]) begin
        seen[w] = 1'b0;
        val[w] = 1'b0;
      end
      // Weight, parity and majority masks, and symmetry by minterm weight.
      for (int p = 0; p < sz; p++) begin
        pw = $countones(6'(p));
        v.ones += 7'(t[p]);
        if (pw % 2 == 1) par[p] = 1'b1;
        if (pw >= 2) mj[p] = 1'b1;
        if (!seen[pw]) begin
          seen[pw] = 1'b1;
          val[pw] = t[p];
        end else if (val[pw] != t[p]) begin
          v.sym = 1'b0;
        end
      end
      // Moebius transform one lane at a time; compare cofactors for unateness.
      anf = t;
      for (int i = 0; i < n; i++) begin
        lo = t & LANE_ZERO[i];
        hi = (t >> (1 << i)) & LANE_ZERO[i];
        anf ^= (anf & LANE_ZERO[i]) << (1 << i);
        if ((lo & ~hi) != 0) v.mono = 1'b0;
        if ((hi & ~lo) != 0) v.anti = 1'b0;
        else v.nunate++;
      end
      for (int p = 0; p < sz; p++)
        if (anf[p] && $countones(6'(p)) > top) top = $countones(6'(p));
      v.deg = 3'(top);
      v.affine = (top <= 1);

      if (t == 0) v.cls = ttfc_pkg::CLS_CONST0;
      else if (t == vm) v.cls = ttfc_pkg::CLS_CONST1;
      else if (n == 1)
        v.cls = (t == 2) ? ttfc_pkg::CLS_BUF : ((t == 1) ? ttfc_pkg::CLS_INV : ttfc_pkg::CLS_NONE);
      else if (t == (64'd1 << full)) v.cls = ttfc_pkg::CLS_AND;
      else if (t == (vm & ~(64'd1 << full))) v.cls = ttfc_pkg::CLS_NAND;
      else if (t == (vm & ~64'd1)) v.cls = ttfc_pkg::CLS_OR;
      else if (t == 64'd1) v.cls = ttfc_pkg::CLS_NOR;
      else if (t == (par & vm)) v.cls = ttfc_pkg::CLS_XOR;
      else if (t == (vm & ~par)) v.cls = ttfc_pkg::CLS_XNOR;
      else if (n == 3 && t == (mj & vm)) v.cls = ttfc_pkg::CLS_MAJ;
      else if (n == 3 && t == (vm & ~mj)) v.cls = ttfc_pkg::CLS_MAJI;
      else if (v.mono)
        v.cls = (!t[0] && t[full]) ? ttfc_pkg::CLS_AO : ttfc_pkg::CLS_NONE;
      else if (v.anti)
        v.cls = (t[0] && !t[full]) ? ttfc_pkg::CLS_AOI : ttfc_pkg::CLS_NONE;
      else v.cls = ttfc_pkg::CLS_NONE;

      case (v.cls)
        ttfc_pkg::CLS_BUF:  v.cost = 6'd4;
        ttfc_pkg::CLS_INV:  v.cost = 6'd2;
        ttfc_pkg::CLS_NAND, ttfc_pkg::CLS_NOR, ttfc_pkg::CLS_AOI:
          v.cost = 6'(2 * n);
        ttfc_pkg::CLS_AND, ttfc_pkg::CLS_OR, ttfc_pkg::CLS_AO:
          v.cost = 6'(2 * n + 2);
        ttfc_pkg::CLS_XOR, ttfc_pkg::CLS_XNOR:
          v.cost = (n >= 2) ? 6'(10 + 8 * (n - 2)) : 6'd0;
        ttfc_pkg::CLS_MAJ:  v.cost = 6'd12;
        ttfc_pkg::CLS_MAJI: v.cost = 6'd10;
        default:            v.cost = 6'd0;
      endcase
      case (v.cls)
        ttfc_pkg::CLS_BUF: v.inv = 2'd2;
        ttfc_pkg::CLS_AND, ttfc_pkg::CLS_OR, ttfc_pkg::CLS_AO, ttfc_pkg::CLS_MAJ:
          v.inv = 2'd1;
        default:           v.inv = 2'd0;
      endcase
      return v;
    endfunction

    function void note_table(bit [2:0] cnt, bit [63:0] tbl);
      pending = {pending, classify(cnt, tbl)};
    endfunction

    function void judge(string field, logic [6:0] want, logic [6:0] got);
      if (got !== want) begin
        faults++;
        if (faults <= 10)
          $display("mismatch on %s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        faults++;
        if (faults <= 10) $display("result arrived with no table pending");
        return;
      end
      want = pending.pop_front();
      judge("gate_class", want.cls, got.cls);
      judge("ones_count", want.ones, got.ones);
      judge("alg_degree", want.deg, got.deg);
      judge("affine_flag", want.affine, got.affine);
      judge("symmetric_flag", want.sym, got.sym);
      judge("monotone_flag", want.mono, got.mono);
      judge("antimonotone_flag", want.anti, got.anti);
      judge("neg_unate_inputs", want.nunate, got.nunate);
      judge("transistor_cost", want.cost, got.cost);
      judge("output_inverters", want.inv, got.inv);
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_input_count = '0;
  logic [63:0] in_truth_table = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_gate_class;
  logic [6:0]  out_ones_count;
  logic [2:0]  out_alg_degree;
  logic        out_affine_flag;
  logic        out_symmetric_flag;
  logic        out_monotone_flag;
  logic        out_antimonotone_flag;
  logic [2:0]  out_neg_unate_inputs;
  logic [5:0]  out_transistor_cost;
  logic [1:0]  out_output_inverters;

  // Shared pacing: steady turns idling off on both sides, and each bump of
  // hold_req asks the result side for one long hold-off.
  bit steady = 1'b0;
  int hold_req = 0;

  feature_ledger board = new();

  truth_table_feature_classifier_core DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_input_count        (in_input_count),
    .in_truth_table        (in_truth_table),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_gate_class        (out_gate_class),
    .out_ones_count        (out_ones_count),
    .out_alg_degree        (out_alg_degree),
    .out_affine_flag       (out_affine_flag),
    .out_symmetric_flag    (out_symmetric_flag),
    .out_monotone_flag     (out_monotone_flag),
    .out_antimonotone_flag (out_antimonotone_flag),
    .out_neg_unate_inputs  (out_neg_unate_inputs),
    .out_transistor_cost   (out_transistor_cost),
    .out_output_inverters  (out_output_inverters)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the core hangs.
  initial begin
    #TIMEOUT_NS;
    $display("FAILURE");
    $finish;
  end

  // Drop valid and let the given number of cycles pass.
  task automatic pause(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Offer one item, hold it until accepted, then record what it owes.
  // Optionally idle afterwards for a random burst.
  task automatic offer(bit [2:0] cnt, bit [63:0] tbl, bit may_idle = 1'b1);
    in_valid <= 1'b1;
    in_input_count <= cnt;
    in_truth_table <= tbl;
    do @(posedge clk); while (in_stall);
    board.note_table(cnt, tbl);
    if (may_idle && !steady && $urandom_range(0, 3) == 0)
      pause($urandom_range(1, 9));
  endtask

  // Draw a table with structure: raw noise, named gates, monotone and
  // antimonotone closures, symmetric functions, near misses and literals.
  // Ignored high bits get random junk about half the time.
  function automatic bit [63:0] draw_table(bit [2:0] cnt);
    int        n, sz, kind, m;
    bit [63:0] vm, junk, par, mj, named, upset, t;
    bit        wv [7];
    n = (cnt > ttfc_pkg::MAX_INPUTS) ? ttfc_pkg::MAX_INPUTS : cnt;
    sz = 1 << n;
    vm = feature_ledger::span_of(n);
    junk = {$urandom, $urandom};
    par = '0;
    mj = '0;
    upset = '0;
    for (int p = 0; p < 64; p++) begin
      par[p] = ^p[5:0];
      mj[p] = ($countones(6'(p)) >= 2);
    end
    case ($urandom_range(0, 9))
      0: named = '0;
      1: named = vm;
      2: named = 64'd1 << (sz - 1);
      3: named = vm & ~(64'd1 << (sz - 1));
      4: named = vm & ~64'd1;
      5: named = 64'd1;
      6: named = par;
      7: named = vm & ~par;
      8: named = mj;
      default: named = vm & ~mj;
    endcase
    // Upward closure of one to three random generator minterms.
    repeat ($urandom_range(1, 3)) begin
      m = $urandom_range(0, sz - 1);
      for (int p = 0; p < sz; p++)
        if ((p & m) == m) upset[p] = 1'b1;
    end
    foreach (wv[w]) wv[w] = 1'($urandom_range(0, 1));

    kind = $urandom_range(0, 11);
    case (kind)
      0, 1:    t = junk;
      2, 3:    t = named;
      4, 5, 6: t = upset;
      7:       t = vm & ~upset;
      8: begin
        t = '0;
        for (int p = 0; p < sz; p++) t[p] = wv[$countones(6'(p))];
      end
      9, 10: begin
        t = (kind == 9) ? named : upset;
        t[$urandom_range(0, sz - 1)] ^= 1'b1;
      end
      default: begin
        if (n == 0) t = junk;
        else begin
          m = $urandom_range(0, n - 1);
          t = $urandom_range(0, 1) ? ~LANE_ZERO[m] : LANE_ZERO[m];
        end
      end
    endcase
    if (kind > 1) t = $urandom_range(0, 1) ? ((t & vm) | (junk & ~vm)) : (t & vm);
    return t;
  endfunction

  // Result side: check each accepted result, then pick the next stall value.
  initial begin : result_side
    int       stall_left;
    int       holds_served;
    verdict_t got;
    stall_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.cls    = ttfc_pkg::gate_class_t'(out_gate_class);
        got.ones   = out_ones_count;
        got.deg    = out_alg_degree;
        got.affine = out_affine_flag;
        got.sym    = out_symmetric_flag;
        got.mono   = out_monotone_flag;
        got.anti   = out_antimonotone_flag;
        got.nunate = out_neg_unate_inputs;
        got.cost   = out_transistor_cost;
        got.inv    = out_output_inverters;
        board.check_result(got);
      end
      // Serve a long hold-off request: count it down here while the input
      // side keeps offering, so both stages fill and in_stall rises.
      if (hold_req != holds_served) begin
        holds_served = hold_req;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (rst_n && !steady && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int       rush;
    bit [2:0] cnt;
    rush = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Hand-picked tables: constants, every gate class, saturation of the
    // input count, junk above the used bits, and unclassified functions.
    offer(3'd0, 64'h0);
    offer(3'd0, 64'hFFFF_FFFF_FFFF_FFFE);
    offer(3'd0, 64'h1);
    offer(3'd1, 64'h2);
    offer(3'd1, 64'hAAAA_AAAA_AAAA_AAA9);
    offer(3'd2, 64'h8);
    offer(3'd2, 64'h7);
    offer(3'd2, 64'hE);
    offer(3'd2, 64'h1);
    offer(3'd2, 64'h6);
    offer(3'd2, 64'h9);
    offer(3'd3, 64'hE8);
    offer(3'd3, 64'h17);
    offer(3'd3, 64'hF8);
    offer(3'd3, 64'h07);
    offer(3'd3, 64'h96);
    offer(3'd4, 64'h6996);
    offer(3'd5, 64'hFFFF_0000_6996_9669);
    offer(3'd6, 64'h8000_0000_0000_0000);
    offer(3'd6, 64'h7FFF_FFFF_FFFF_FFFF);
    offer(3'd6, 64'h6996_9669_9669_6996);
    offer(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    offer(3'd7, 64'h0000_0000_0000_0001);
    offer(3'd4, 64'h6A5C);
    offer(3'd4, 64'h1668);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // Toggle idle-free stretches every block; keep it idle-free at the end.
      if (k % 150 == 0 || k == CALM_FROM)
        steady <= (k >= CALM_FROM) || ($urandom_range(0, 2) == 0);
      // Ask for a long receiver hold-off and push items back to back into it.
      if (k == 400 || k == 1200) begin
        hold_req <= hold_req + 1;
        rush = RUSH_ITEMS;
      end
      cnt = 3'($urandom_range(0, 7));
      offer(cnt, draw_table(cnt), rush == 0);
      if (rush > 0) rush--;
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed result, then keep waiting for strays.
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.faults == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
